@@ sv/ucd_pkg.sv @@
package ucd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CP_W   = 21;
  localparam int unsigned LEN_W  = 3;
  localparam int unsigned REM_W  = 2;

  // Lead byte classes: mask and the pattern it must match
  localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD2_CODE = 8'hC0;
  localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD3_CODE = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
  localparam logic [BYTE_W-1:0] LEAD4_CODE = 8'hF0;

  localparam logic [CP_W-1:0]  REPLACEMENT_CP = 21'h00FFFD;
  localparam logic [LEN_W-1:0] LEN_ONE        = 3'd1;
  localparam logic [LEN_W-1:0] LEN_MAX        = 3'd4;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BAD   = 2'd1,
    ST_TRUNC = 2'd2
  } status_t;

  typedef struct packed {
    logic [CP_W-1:0]  codepoint;
    status_t          status;
    logic [LEN_W-1:0] seq_len;
  } ucd_res_t;

endpackage

@@ sv/ucd_if.sv @@
interface ucd_in_if;
  import ucd_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              end_of_string;

  modport source (output valid, output data_byte, output end_of_string, input ready);
  modport sink   (input valid, input data_byte, input end_of_string, output ready);
endinterface

interface ucd_out_if;
  import ucd_pkg::*;

  logic             valid;
  logic             ready;
  logic [CP_W-1:0]  codepoint;
  logic [1:0]       decode_status;
  logic [LEN_W-1:0] sequence_length;

  modport source (output valid, output codepoint, output decode_status,
                  output sequence_length, input ready);
  modport sink   (input valid, input codepoint, input decode_status,
                  input sequence_length, output ready);
endinterface

@@ sv/ucd_decode.sv @@
module ucd_decode
  import ucd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic              end_of_string,
  output logic              res_valid,
  output ucd_res_t          res
);

  logic [REM_W-1:0] bytes_remaining_r, bytes_remaining_nxt;
  logic [CP_W-1:0]  partial_value_r, partial_value_nxt;
  logic [LEN_W-1:0] bytes_taken_r, bytes_taken_nxt;

  logic [CP_W-1:0]  shifted_cp;
  logic [LEN_W-1:0] taken_inc;
  logic [REM_W-1:0] rem_dec;

  assign shifted_cp = {partial_value_r[CP_W-7:0], data_byte[5:0]};
  assign taken_inc  = bytes_taken_r + LEN_ONE;
  assign rem_dec    = bytes_remaining_r - REM_W'(1);

  // Decode one word against the sequence state
  always_comb begin
    bytes_remaining_nxt = bytes_remaining_r;
    partial_value_nxt   = partial_value_r;
    bytes_taken_nxt     = bytes_taken_r;
    res_valid           = 1'b0;
    res.codepoint       = '0;
    res.status          = ST_OK;
    res.seq_len         = LEN_ONE;

    if (bytes_remaining_r != '0) begin
      // Append six payload bits, top bits unchecked
      partial_value_nxt   = shifted_cp;
      bytes_taken_nxt     = taken_inc;
      bytes_remaining_nxt = rem_dec;
      res.seq_len         = taken_inc;
      if (rem_dec == '0) begin
        res_valid         = 1'b1;
        res.codepoint     = shifted_cp;
        partial_value_nxt = '0;
        bytes_taken_nxt   = '0;
      end else if (end_of_string) begin
        res_valid           = 1'b1;
        res.status          = ST_TRUNC;
        bytes_remaining_nxt = '0;
        partial_value_nxt   = '0;
        bytes_taken_nxt     = '0;
      end
    end else if (!data_byte[BYTE_W-1]) begin
      // Plain ASCII
      res_valid     = 1'b1;
      res.codepoint = CP_W'(data_byte);
    end else if ((data_byte & LEAD2_MASK) == LEAD2_CODE ||
                 (data_byte & LEAD3_MASK) == LEAD3_CODE ||
                 (data_byte & LEAD4_MASK) == LEAD4_CODE) begin
      // Start a multi-byte sequence
      if ((data_byte & LEAD2_MASK) == LEAD2_CODE) begin
        partial_value_nxt   = CP_W'(data_byte[4:0]);
        bytes_remaining_nxt = REM_W'(1);
      end else if ((data_byte & LEAD3_MASK) == LEAD3_CODE) begin
        partial_value_nxt   = CP_W'(data_byte[3:0]);
        bytes_remaining_nxt = REM_W'(2);
      end else begin
        partial_value_nxt   = CP_W'(data_byte[2:0]);
        bytes_remaining_nxt = REM_W'(3);
      end
      bytes_taken_nxt = LEN_ONE;
      if (end_of_string) begin
        res_valid           = 1'b1;
        res.status          = ST_TRUNC;
        bytes_remaining_nxt = '0;
        partial_value_nxt   = '0;
        bytes_taken_nxt     = '0;
      end
    end else begin
      // Stray continuation or invalid lead
      res_valid     = 1'b1;
      res.codepoint = REPLACEMENT_CP;
      res.status    = ST_BAD;
    end
  end

  // Advance sequence state only on a processed word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_remaining_r <= '0;
      partial_value_r   <= '0;
      bytes_taken_r     <= '0;
    end else if (step_en) begin
      bytes_remaining_r <= bytes_remaining_nxt;
      partial_value_r   <= partial_value_nxt;
      bytes_taken_r     <= bytes_taken_nxt;
    end
  end

  a_idle_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && res_valid |=> bytes_remaining_r == '0)
    else $error("sequence state not idle after a result");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bytes_remaining_r != '0 |->
      (LEN_W'(bytes_remaining_r) + bytes_taken_r) <= LEN_MAX)
    else $error("sequence longer than four bytes");

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    !step_en |=> $stable(bytes_remaining_r) && $stable(bytes_taken_r))
    else $error("sequence state moved without a word");

  a_lead_starts_count: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && bytes_remaining_r == '0 && !res_valid |=>
      bytes_taken_r == LEN_ONE && bytes_remaining_r != '0)
    else $error("lead byte did not open a sequence");

endmodule

@@ sv/utf8_codepoint_decoder.sv @@
// Streaming UTF-8 decoder, one byte per word.
// in_ch carries a raw byte and an end-of-string flag; out_ch carries the
// code point, a status (decoded, replacement, truncated) and the number of
// bytes that the result consumed. ASCII and invalid bytes give one result
// each; a multi-byte sequence gives one result on its last byte, or a
// truncation result when the string ends early. Continuation bytes that
// do not end a sequence give no result.
// A word accepted on the input handshake is registered in the input
// register, decoded, and loaded into the result register once that
// register is free; out_ch.valid then stays high until it is taken.
// Throughput: one byte per cycle while the result register is free, set
// by the single input register and the result register with one decode
// step between them.
// Reset (synchronous, rst_n low) empties both registers and returns the
// sequence state to idle. When the receiver holds out_ch.ready low with a
// result waiting, the input register fills and then in_ch.ready drops; a
// word that gives no result still waits for the result register to free.
module utf8_codepoint_decoder
  import ucd_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  ucd_in_if.sink         in_ch,
  ucd_out_if.source      out_ch
);

  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              s1_eos_r;
  logic              s1_adv;
  logic              out_free;
  logic              out_valid_r;
  ucd_res_t          out_res_r;
  logic              dec_valid;
  ucd_res_t          dec_res;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign s1_adv      = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || s1_adv;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_byte_r <= in_ch.data_byte;
      s1_eos_r  <= in_ch.end_of_string;
    end
  end

  ucd_decode u_decode (
    .clk           (clk),
    .rst_n         (rst_n),
    .step_en       (s1_adv),
    .data_byte     (s1_byte_r),
    .end_of_string (s1_eos_r),
    .res_valid     (dec_valid),
    .res           (dec_res)
  );

  // Result register: load on a decoded result, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_adv && dec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && dec_valid) begin
      out_res_r <= dec_res;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.codepoint       = out_res_r.codepoint;
  assign out_ch.decode_status   = out_res_r.status;
  assign out_ch.sequence_length = out_res_r.seq_len;

endmodule

@@ bench/utf8_codepoint_decoder_tb.sv @@
module utf8_codepoint_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ucd_pkg::*;

  localparam int QUIET_LIMIT = 1000;
  localparam int HOLD_CYCLES = 150;
  localparam int PHASE_BYTES = 360;
  localparam int TAIL_CYCLES = 8;

  // Directed bytes, {end_of_string, data_byte}
  localparam logic [8:0] DIRECTED [23] = '{
    9'h000, 9'h17F,                       // ASCII extremes, flag on a single byte
    9'h0C2, 9'h0A9,                       // two-byte sequence
    9'h0E2, 9'h082, 9'h1AC,               // three-byte, flag on the completing byte
    9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF,       // four-byte, all value bits set
    9'h0C0, 9'h000,                       // non-continuation byte taken mid-sequence
    9'h080, 9'h0BF,                       // stray continuation bytes
    9'h0F8, 9'h0FF,                       // invalid leads
    9'h1C3,                               // lead on the last byte
    9'h0E2, 9'h182,                       // three-byte cut short
    9'h0F0, 9'h09F, 9'h198                // four-byte cut short
  };

  // Predict decoded code points and hold them until the block returns them
  class codepoint_board;
    logic [REM_W-1:0] remaining;
    logic [CP_W-1:0]  partial;
    logic [LEN_W-1:0] taken;
    ucd_res_t         expected_cps[$];
    int               mismatches;

    function new();
      remaining   = '0;
      partial     = '0;
      taken       = '0;
      mismatches  = 0;
    endfunction

    function int pending();
      return expected_cps.size();
    endfunction

    function void push_cp(logic [CP_W-1:0] cp, status_t st, logic [LEN_W-1:0] len);
      ucd_res_t r;
      r.codepoint = cp;
      r.status    = st;
      r.seq_len   = len;
      expected_cps.push_back(r);
    endfunction

    function void take_byte(logic [BYTE_W-1:0] b, logic eos);
      bit started;
      started = 1'b0;
      if (remaining != '0) begin
        // any byte counts as a continuation: append its low six bits
        partial   = {partial[CP_W-7:0], b[5:0]};
        taken     = taken + LEN_ONE;
        remaining = remaining - REM_W'(1);
        if (remaining == '0) begin
          push_cp(partial, ST_OK, taken);
          partial = '0;
          taken   = '0;
        end else if (eos) begin
          push_cp('0, ST_TRUNC, taken);
          remaining = '0;
          partial   = '0;
          taken     = '0;
        end
      end else if (!b[7]) begin
        push_cp(CP_W'(b), ST_OK, LEN_ONE);
      end else begin
        started = 1'b1;
        if ((b & LEAD2_MASK) == LEAD2_CODE) begin
          partial   = CP_W'(b[4:0]);
          remaining = 2'd1;
        end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
          partial   = CP_W'(b[3:0]);
          remaining = 2'd2;
        end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
          partial   = CP_W'(b[2:0]);
          remaining = 2'd3;
        end else begin
          // stray continuation or 0xF8..0xFF lead
          started = 1'b0;
          push_cp(REPLACEMENT_CP, ST_BAD, LEN_ONE);
        end
        if (started) begin
          taken = LEN_ONE;
          // lead on the last byte of the string
          if (eos) begin
            push_cp('0, ST_TRUNC, LEN_ONE);
            remaining = '0;
            partial   = '0;
            taken     = '0;
          end
        end
      end
    endfunction

    function void match_result(logic [CP_W-1:0] cp, logic [1:0] st, logic [LEN_W-1:0] len);
      ucd_res_t want;
      if (expected_cps.size() == 0) begin
        $error("unexpected result word: codepoint %0h status %0d length %0d", cp, st, len);
        mismatches++;
        return;
      end
      want = expected_cps.pop_front();
      if (cp !== want.codepoint) begin
        $error("codepoint: expected %0h, got %0h", want.codepoint, cp);
        mismatches++;
      end
      if (st !== want.status) begin
        $error("decode_status: expected %0d, got %0d", want.status, st);
        mismatches++;
      end
      if (len !== want.seq_len) begin
        $error("sequence_length: expected %0d, got %0d", want.seq_len, len);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ucd_in_if  in_ch();
  ucd_out_if out_ch();

  utf8_codepoint_decoder DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  codepoint_board board = new();
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_request   = 1'b0;
  int quiet_cycles   = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Offer one word and hold it until the block takes it
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eos);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.data_byte     <= b;
    in_ch.end_of_string <= eos;
    do @(posedge clk); while (!in_ch.ready);
    board.take_byte(b, eos);
  endtask

  // Stop offering and wait for every predicted result
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  // Build one string: mostly well-formed characters, some noise,
  // sometimes ending in the middle of a sequence
  task automatic make_string(ref logic [8:0] str[$]);
    int n_chars;
    int kind;
    int need;
    int keep;
    logic [7:0] rb;
    logic [7:0] lead;
    str.delete();
    n_chars = $urandom_range(10, 1);
    for (int c = 0; c < n_chars; c++) begin
      kind = $urandom_range(99);
      rb   = 8'($urandom);
      if (kind < 25) begin
        str.push_back({1'b0, 1'b0, rb[6:0]});
      end else if (kind < 88) begin
        need = (kind < 45) ? 1 : (kind < 65) ? 2 : 3;
        lead = (need == 1) ? {3'b110, rb[4:0]} :
               (need == 2) ? {4'b1110, rb[3:0]} : {5'b11110, rb[2:0]};
        keep = need;
        if (c == n_chars - 1 && $urandom_range(3) == 0)
          keep = $urandom_range(need - 1);
        str.push_back({1'b0, lead});
        repeat (keep) begin
          rb = 8'($urandom);
          // mostly proper continuation bytes, now and then any byte
          if ($urandom_range(19) == 0)
            str.push_back({1'b0, rb});
          else
            str.push_back({1'b0, 2'b10, rb[5:0]});
        end
      end else if (kind < 92) begin
        str.push_back({1'b0, 2'b10, rb[5:0]});
      end else if (kind < 96) begin
        str.push_back({1'b0, 5'b11111, rb[2:0]});
      end else begin
        str.push_back({1'b0, rb});
      end
    end
    str[str.size() - 1][8] = 1'b1;
  endtask

  // Receive results: check at the edge, then pick the next ready
  initial begin
    int hold_left;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready)
        board.match_result(out_ch.codepoint, out_ch.decode_status, out_ch.sequence_length);
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("utf8_codepoint_decoder_tb: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Main sequence
  initial begin
    logic [8:0] str[$];
    int sent;
    bit held;
    in_ch.valid         <= 1'b0;
    in_ch.data_byte     <= '0;
    in_ch.end_of_string <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[i]) send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);
    drain();

    // random strings under four idling patterns
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
        default: begin send_idle_pct = 30; recv_stall_pct = 30; end
      endcase
      sent = 0;
      held = 1'b0;
      while (sent < PHASE_BYTES) begin
        make_string(str);
        foreach (str[i]) begin
          send_byte(str[i][7:0], str[i][8]);
          sent++;
          // long receiver hold-off while input keeps coming
          if (phase == 0 && !held && sent >= 120) begin
            hold_request = 1'b1;
            held         = 1'b1;
          end
        end
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("utf8_codepoint_decoder_tb: done, clean");
    end else begin
      if (board.pending() != 0)
        $error("%0d expected results never arrived", board.pending());
      $display("utf8_codepoint_decoder_tb: done, errors");
    end
    $finish;
  end

endmodule
